>>> rtl/psc_pkg.sv
// Package for the stream pattern censor: payload types, constants, register map.
package psc_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int PAT_BYTES   = 16;
  localparam int PAT_IDX_W   = 4;
  localparam int LEN_REG_W   = 5;
  localparam int DATA_W      = 64;
  localparam int ADDR_W      = 5;

  localparam logic [7:0] STAR = 8'h2A;

  typedef enum logic [1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2,
    REG_NONE           = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } psc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } psc_out_t;

  // per-cycle control broadcast along the cell row
  typedef struct packed {
    logic shift;
    logic star;
  } cell_ctrl_t;

endpackage

>>> rtl/psc_cfg.sv
// Configuration registers with APB-style access; effective length and aligned pattern.
module psc_cfg #(
  parameter int MAX_PATTERN = psc_pkg::MAX_PATTERN,
  localparam int LEN_W = $clog2(MAX_PATTERN + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [psc_pkg::ADDR_W-1:0]      paddr,
  input  logic [psc_pkg::DATA_W-1:0]      pwdata,
  output logic [psc_pkg::DATA_W-1:0]      prdata,
  output logic                            pready,
  output logic [LEN_W-1:0]                eff_len,
  output logic [MAX_PATTERN-1:0][7:0]     cell_pat,
  output logic [MAX_PATTERN-1:0]          cell_in_win
);

  logic [psc_pkg::LEN_REG_W-1:0] pattern_length;
  logic [psc_pkg::DATA_W-1:0]    pattern_low;
  logic [psc_pkg::DATA_W-1:0]    pattern_high;
  logic [2*psc_pkg::DATA_W-1:0]  pattern_all;
  psc_pkg::reg_index_t           reg_sel;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_sel = psc_pkg::reg_index_t'(paddr[4:3]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= psc_pkg::LEN_REG_W'(1);
      pattern_low    <= '0;
      pattern_high   <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        psc_pkg::REG_PATTERN_LENGTH: begin
          pattern_length <= pwdata[psc_pkg::LEN_REG_W-1:0];
        end
        psc_pkg::REG_PATTERN_LOW: begin
          pattern_low <= pwdata;
        end
        psc_pkg::REG_PATTERN_HIGH: begin
          pattern_high <= pwdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      psc_pkg::REG_PATTERN_LENGTH: begin
        prdata = psc_pkg::DATA_W'(pattern_length);
      end
      psc_pkg::REG_PATTERN_LOW: begin
        prdata = pattern_low;
      end
      psc_pkg::REG_PATTERN_HIGH: begin
        prdata = pattern_high;
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  // zero acts as one, anything above the maximum as the maximum
  always_comb begin
    priority if (pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (pattern_length > psc_pkg::LEN_REG_W'(MAX_PATTERN)) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = LEN_W'(pattern_length);
    end
  end

  assign pattern_all = {pattern_high, pattern_low};

  // cell k holds the byte from k requests ago, so it faces pattern byte len-1-k
  always_comb begin
    logic [psc_pkg::PAT_IDX_W-1:0] idx;
    idx = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      idx            = psc_pkg::PAT_IDX_W'(32'(eff_len) - 32'(k) - 32'd1);
      cell_pat[k]    = pattern_all[8*idx +: 8];
      cell_in_win[k] = (LEN_W'(k) < eff_len);
    end
  end

endmodule

>>> rtl/psc_cell.sv
// One cell of the byte row: holds a byte and its last flag, compares against its pattern byte.
module psc_cell (
  input  logic                clk,
  input  psc_pkg::cell_ctrl_t ctrl,
  input  psc_pkg::psc_out_t   prev,
  input  logic [7:0]          pat_byte,
  input  logic                in_win,
  output psc_pkg::psc_out_t   held,
  output logic                ok
);

  // compare what is about to move in
  assign ok = ~in_win | (prev.out_byte == pat_byte);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      held.out_byte <= (ctrl.star & in_win) ? psc_pkg::STAR : prev.out_byte;
      held.out_last <= prev.out_last;
    end
  end

endmodule

>>> rtl/stream_pattern_censor.sv
// Top level of the stream pattern censor: control counters and the row of byte cells.
//
//   channel   direction  handshake             payload
//   src       in         src_valid/src_stall   data_byte, end_of_stream
//   dst       out        dst_valid/dst_stall   out_byte, out_last
//   cfg       in         psel/penable/pready   pattern_length, pattern bytes (64-bit regs)
//
// One byte enters and one byte leaves per cycle unless stalled; no request waits on a match.
// A byte is readable the cycle after the request that settles it: a match, end of stream,
// or being pushed out of a full window (pattern length minus one later requests).
// A match turns the window cells into stars in place, so a burst never stalls the input.
// Bytes move through a row of MAX_PATTERN+2 cells; src_stall rises only when all are full.
// Reset is synchronous and empties the row; the window contents need no clearing.
module stream_pattern_censor #(
  parameter int MAX_PATTERN = psc_pkg::MAX_PATTERN
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        src_valid,
  output logic                        src_stall,
  input  psc_pkg::psc_in_t            src_data,
  output logic                        dst_valid,
  input  logic                        dst_stall,
  output psc_pkg::psc_out_t           dst_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psc_pkg::ADDR_W-1:0]  paddr,
  input  logic [psc_pkg::DATA_W-1:0]  pwdata,
  output logic [psc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int DEPTH = MAX_PATTERN + 2;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  logic [LEN_W-1:0]             eff_len;
  logic [MAX_PATTERN-1:0][7:0]  cell_pat;
  logic [MAX_PATTERN-1:0]       cell_in_win;

  // count: bytes not yet delivered; win: newest of them still pending a decision
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [LEN_W-1:0]   win;
  logic [LEN_W-1:0]   win_next;
  logic [LEN_W-1:0]   win_inc;
  logic [LEN_W-1:0]   new_win;
  logic               src_take;
  logic               dst_take;
  logic               full;
  logic               match;
  logic [IDX_W-1:0]   head_idx;

  psc_pkg::cell_ctrl_t ctrl;
  psc_pkg::psc_out_t   cell_q  [DEPTH];
  psc_pkg::psc_out_t   cell_in [DEPTH];
  logic [DEPTH-1:0]    cell_ok;

  psc_cfg #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .eff_len     (eff_len),
    .cell_pat    (cell_pat),
    .cell_in_win (cell_in_win)
  );

  assign src_stall = (count == CNT_W'(DEPTH));
  assign src_take  = src_valid & ~src_stall;
  assign dst_valid = (count > CNT_W'(win));
  assign dst_take  = dst_valid & ~dst_stall;

  assign head_idx  = IDX_W'(count - CNT_W'(1));
  assign dst_data  = cell_q[head_idx];

  // surplus bytes left by a lowered length are committed unchanged
  assign win_inc = win + LEN_W'(1);
  assign new_win = (win_inc > eff_len) ? eff_len : win_inc;
  assign full    = (new_win == eff_len);
  assign match   = full & (&cell_ok);

  assign ctrl.shift = src_take;
  assign ctrl.star  = match;

  assign cell_in[0].out_byte = src_data.data_byte;
  assign cell_in[0].out_last = src_data.end_of_stream;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k > 0) begin : g_link
      assign cell_in[k] = cell_q[k-1];
    end
    if (k < MAX_PATTERN) begin : g_win
      psc_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .prev     (cell_in[k]),
        .pat_byte (cell_pat[k]),
        .in_win   (cell_in_win[k]),
        .held     (cell_q[k]),
        .ok       (cell_ok[k])
      );
    end else begin : g_tail
      psc_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .prev     (cell_in[k]),
        .pat_byte (8'h00),
        .in_win   (1'b0),
        .held     (cell_q[k]),
        .ok       (cell_ok[k])
      );
    end
  end

  always_comb begin
    count_next = count + CNT_W'(src_take) - CNT_W'(dst_take);
    win_next   = win;
    if (src_take) begin
      priority if (src_data.end_of_stream) begin
        win_next = '0;
      end else if (match) begin
        win_next = '0;
      end else if (full) begin
        win_next = eff_len - LEN_W'(1);
      end else begin
        win_next = new_win;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      win   <= '0;
    end else begin
      count <= count_next;
      win   <= win_next;
    end
  end

endmodule
